### rtl/npms_pkg.sv
// Shared types and constants for the nearest point Manhattan search block.
`timescale 1ns / 1ps

package npms_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int ABS_W      = 32;
    localparam int DIST_W     = 34;
    localparam int IDX_W      = 10;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 34'd65470464;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] nearest_distance;
        logic              found_within;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    // Issue side of the distance unit
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
    } dist_ctrl_t;

    // Result side of the distance unit
    typedef struct packed {
        logic              busy;
        logic              valid;
        logic [ADDR_W-1:0] tag;
    } dist_res_t;

endpackage

### rtl/npms_dist_unit.sv
// Shared two-stage L1 distance unit: absolute differences, then their sum.
`timescale 1ns / 1ps

module npms_dist_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  npms_pkg::dist_ctrl_t              in_ctrl,
    input  npms_pkg::point_t                  query,
    input  npms_pkg::point_t                  stored,
    output npms_pkg::dist_res_t               out_ctrl,
    output logic [npms_pkg::DIST_W-1:0]       distance
);

    logic                             s1_valid_reg;
    logic [npms_pkg::ADDR_W-1:0]      s1_tag_reg;
    logic [npms_pkg::ABS_W-1:0]       ax_reg;
    logic [npms_pkg::ABS_W-1:0]       ay_reg;
    logic [npms_pkg::ABS_W-1:0]       az_reg;
    logic                             s2_valid_reg;
    logic [npms_pkg::ADDR_W-1:0]      s2_tag_reg;
    logic [npms_pkg::DIST_W-1:0]      sum_reg;

    logic [npms_pkg::ABS_W-1:0]       ax_next;
    logic [npms_pkg::ABS_W-1:0]       ay_next;
    logic [npms_pkg::ABS_W-1:0]       az_next;
    logic [npms_pkg::DIST_W-1:0]      sum_next;

    // Absolute difference: both subtractions side by side, pick by sign
    function automatic logic [npms_pkg::ABS_W-1:0] abs_diff(
        input logic signed [npms_pkg::COORD_W-1:0] a,
        input logic signed [npms_pkg::COORD_W-1:0] b
    );
        logic [npms_pkg::COORD_W:0] d_ab;
        logic [npms_pkg::COORD_W:0] d_ba;
        d_ab = {a[npms_pkg::COORD_W-1], a} - {b[npms_pkg::COORD_W-1], b};
        d_ba = {b[npms_pkg::COORD_W-1], b} - {a[npms_pkg::COORD_W-1], a};
        abs_diff = d_ab[npms_pkg::COORD_W] ? d_ba[npms_pkg::ABS_W-1:0]
                                           : d_ab[npms_pkg::ABS_W-1:0];
    endfunction

    always_comb
    begin
        ax_next  = abs_diff(query.x, stored.x);
        ay_next  = abs_diff(query.y, stored.y);
        az_next  = abs_diff(query.z, stored.z);
        sum_next = npms_pkg::DIST_W'(ax_reg) + npms_pkg::DIST_W'(ay_reg)
                 + npms_pkg::DIST_W'(az_reg);
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_ctrl.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= in_ctrl.tag;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        s2_tag_reg <= s1_tag_reg;
        sum_reg    <= sum_next;
    end

    assign out_ctrl.busy  = s1_valid_reg;
    assign out_ctrl.valid = s2_valid_reg;
    assign out_ctrl.tag   = s2_tag_reg;
    assign distance       = sum_reg;

endmodule

### rtl/nearest_point_manhattan_search.sv
// Top level of the nearest point Manhattan search: point store and query sequencer.
`timescale 1ns / 1ps

// Load and clear words never stall the input. A query word stalls the input
// while the point store is scanned: the single read port of the point store
// hands one point per cycle to a shared distance unit, whose two stages and the
// final compare must then drain before the result word is registered. A result
// word still held by out_stall keeps the input stalled until it is taken. Loads
// past the store's capacity of 1024 points are dropped; command code 3 is
// ignored. The user must write the distance limit through cfg_write/cfg_data
// only while idle; the block itself does not enforce it.
module nearest_point_manhattan_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [npms_pkg::DIST_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  npms_pkg::in_word_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output npms_pkg::out_word_t            out_word
);

    npms_pkg::state_t                 state_reg;
    npms_pkg::state_t                 state_next;
    logic [npms_pkg::DIST_W-1:0]      limit_reg;
    logic [npms_pkg::CNT_W-1:0]       count_reg;
    logic [npms_pkg::CNT_W-1:0]       idx_reg;
    npms_pkg::point_t                 query_reg;
    npms_pkg::point_t                 rd_data_reg;
    logic                             rd_valid_reg;
    logic [npms_pkg::ADDR_W-1:0]      rd_tag_reg;
    logic [npms_pkg::DIST_W-1:0]      best_reg;
    logic [npms_pkg::ADDR_W-1:0]      best_idx_reg;
    logic                             found_reg;
    logic                             out_valid_reg;
    npms_pkg::out_word_t              out_word_reg;

    npms_pkg::point_t                 mem [npms_pkg::MAX_POINTS];

    logic                             load_en;
    logic                             clear_en;
    logic                             start_en;
    logic                             issue_en;
    logic                             scan_end;
    logic                             drained;
    logic                             finish_en;
    npms_pkg::point_t                 in_point;
    npms_pkg::dist_ctrl_t             dist_ctrl;
    npms_pkg::dist_res_t              dist_res;
    logic [npms_pkg::DIST_W-1:0]      dist_value;

    assign in_point.x     = in_word.x_coord;
    assign in_point.y     = in_word.y_coord;
    assign in_point.z     = in_word.z_coord;
    assign scan_end       = (idx_reg >= count_reg);
    assign drained        = !rd_valid_reg && !dist_res.busy && !dist_res.valid;
    assign dist_ctrl.valid = rd_valid_reg;
    assign dist_ctrl.tag   = rd_tag_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            npms_pkg::ST_IDLE:
            begin
                if (start_en)
                    state_next = npms_pkg::ST_SCAN;
            end
            npms_pkg::ST_SCAN:
            begin
                if (scan_end)
                    state_next = npms_pkg::ST_DRAIN;
            end
            npms_pkg::ST_DRAIN:
            begin
                if (drained)
                    state_next = npms_pkg::ST_DONE;
            end
            npms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = npms_pkg::ST_IDLE;
            end
            default:
                state_next = npms_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs; the input is never stalled while idle
    always_comb
    begin
        in_stall  = 1'b1;
        load_en   = 1'b0;
        clear_en  = 1'b0;
        start_en  = 1'b0;
        issue_en  = 1'b0;
        finish_en = 1'b0;
        unique case (state_reg)
            npms_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (in_word.command)
                        npms_pkg::CMD_LOAD:
                            load_en = (count_reg < npms_pkg::CNT_W'(npms_pkg::MAX_POINTS));
                        npms_pkg::CMD_QUERY:
                            start_en = 1'b1;
                        npms_pkg::CMD_CLEAR:
                            clear_en = 1'b1;
                        default:
                            ;
                    endcase
                end
            end
            npms_pkg::ST_SCAN:
                issue_en = !scan_end;
            npms_pkg::ST_DRAIN:
                ;
            npms_pkg::ST_DONE:
                finish_en = !out_valid_reg || !out_stall;
            default:
                ;
        endcase
    end

    // Advance state, point count, limit and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npms_pkg::ST_IDLE;
            limit_reg     <= npms_pkg::LIMIT_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue_en;
            if (cfg_write)
                limit_reg <= cfg_data;
            if (clear_en)
                count_reg <= '0;
            else if (load_en)
                count_reg <= count_reg + 1'b1;
            if (start_en)
                idx_reg <= '0;
            else if (issue_en)
                idx_reg <= idx_reg + 1'b1;
            if (start_en)
                found_reg <= 1'b0;
            else if (dist_res.valid && (dist_value < best_reg))
                found_reg <= 1'b1;
            if (finish_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold query point and running best
    always_ff @(posedge clk)
    begin
        if (start_en)
        begin
            query_reg    <= in_point;
            best_reg     <= limit_reg;
            best_idx_reg <= '0;
        end
        else if (dist_res.valid && (dist_value < best_reg))
        begin
            best_reg     <= dist_value;
            best_idx_reg <= dist_res.tag;
        end
        if (finish_en)
        begin
            out_word_reg.nearest_index    <= npms_pkg::IDX_W'(best_idx_reg);
            out_word_reg.nearest_distance <= best_reg;
            out_word_reg.found_within     <= found_reg;
        end
    end

    // Point store: write on load, registered read during a scan
    always_ff @(posedge clk)
    begin
        if (load_en)
            mem[count_reg[npms_pkg::ADDR_W-1:0]] <= in_point;
        if (issue_en)
        begin
            rd_data_reg <= mem[idx_reg[npms_pkg::ADDR_W-1:0]];
            rd_tag_reg  <= idx_reg[npms_pkg::ADDR_W-1:0];
        end
    end

    npms_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctrl  (dist_ctrl),
        .query    (query_reg),
        .stored   (rd_data_reg),
        .out_ctrl (dist_res),
        .distance (dist_value)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### sim/tb_nearest_point_manhattan_search.sv
// Testbench for the nearest point Manhattan search: directed and random words against a predictor.
`timescale 1ns / 1ps

module tb_nearest_point_manhattan_search;

    localparam logic [1:0]                  CMD_UNUSED    = 2'd3;
    localparam logic [npms_pkg::DIST_W-1:0] LIMIT_MAX     = {npms_pkg::DIST_W{1'b1}};
    localparam logic [npms_pkg::DIST_W-1:0] LIMIT_FIFTY   = 34'd3276800;
    localparam logic [npms_pkg::DIST_W-1:0] WORST_L1      = 34'd12884901885;
    localparam int                          PHASE_WORDS   = 94;
    localparam int                          SETTLE_CYCLES = 12;
    localparam int                          CYCLE_LIMIT   = 10000000;
    localparam int                          HOLD_CYCLES   = 500;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [npms_pkg::DIST_W-1:0]   cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    npms_pkg::in_word_t            in_word;
    logic                          out_valid;
    logic                          out_stall;
    npms_pkg::out_word_t           out_word;

    // Predictor state: stored points, their count and the active limit
    npms_pkg::point_t              stored_points [npms_pkg::MAX_POINTS];
    int                            stored_count;
    logic [npms_pkg::DIST_W-1:0]   active_limit;
    npms_pkg::out_word_t           pending_results [$];
    npms_pkg::out_word_t           expected_word;

    int                  error_count;
    int                  queries_checked;
    int                  matches_seen;
    int                  dropped_loads;
    int                  words_sent;
    bit                  no_idle;
    int                  hold_request;
    int                  stall_left;

    nearest_point_manhattan_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Stop a hung run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** nearest_point_manhattan_search: FAILED **");
        $finish;
    end

    // Sum the three absolute coordinate differences
    function automatic logic [npms_pkg::DIST_W-1:0] l1_distance(npms_pkg::point_t a,
                                                                npms_pkg::point_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        return npms_pkg::DIST_W'(dx + dy + dz);
    endfunction

    // Scan the stored points in slot order; keep the first strictly better one
    function automatic npms_pkg::out_word_t nearest_to(npms_pkg::point_t q);
        npms_pkg::out_word_t         r;
        logic [npms_pkg::DIST_W-1:0] best;
        logic [npms_pkg::DIST_W-1:0] d;
        best            = active_limit;
        r.nearest_index = '0;
        r.found_within  = 1'b0;
        for (int i = 0; i < stored_count; i++)
        begin
            d = l1_distance(q, stored_points[i]);
            if (d < best)
            begin
                best            = d;
                r.nearest_index = npms_pkg::IDX_W'(i);
                r.found_within  = 1'b1;
            end
        end
        r.nearest_distance = best;
        return r;
    endfunction

    // Advance the predictor by one accepted word
    task automatic apply_word(npms_pkg::in_word_t w);
        case (w.command)
            npms_pkg::CMD_LOAD:
            begin
                if (stored_count < npms_pkg::MAX_POINTS)
                begin
                    stored_points[stored_count] = '{w.x_coord, w.y_coord, w.z_coord};
                    stored_count++;
                end
                else
                    dropped_loads++;
            end
            npms_pkg::CMD_CLEAR: stored_count = 0;
            npms_pkg::CMD_QUERY:
                pending_results.push_back(nearest_to('{w.x_coord, w.y_coord, w.z_coord}));
            default: ;
        endcase
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        npms_pkg::in_word_t w;
        int                 gap;
        w.command = cmd;
        w.x_coord = x;
        w.y_coord = y;
        w.z_coord = z;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        apply_word(w);
        words_sent++;
    endtask

    // Drop valid, drain all results and let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(logic [npms_pkg::DIST_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        active_limit = value;
    endtask

    // Draw a coordinate: extremes, full range, or near a cluster centre
    function automatic logic [31:0] random_coord(logic [31:0] centre);
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return centre + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [31:0] jitter(logic [31:0] base, logic [31:0] spread);
        return base + $urandom_range(0, spread) - (spread >> 1);
    endfunction

    // Hold the output side for a drawn number of cycles per result word
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left = no_idle ? 0 : $urandom_range(0, 9);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
        else
            out_stall <= 1'b0;
    end

    // Check each taken result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: nearest_index %0d nearest_distance %0d",
                       out_word.nearest_index, out_word.nearest_distance);
                error_count++;
            end
            else
            begin
                expected_word = pending_results.pop_front();
                queries_checked++;
                if (expected_word.found_within)
                    matches_seen++;
                if (out_word.nearest_index !== expected_word.nearest_index)
                begin
                    $error("nearest_index: expected %0d, actual %0d",
                           expected_word.nearest_index, out_word.nearest_index);
                    error_count++;
                end
                if (out_word.nearest_distance !== expected_word.nearest_distance)
                begin
                    $error("nearest_distance: expected %0d, actual %0d",
                           expected_word.nearest_distance, out_word.nearest_distance);
                    error_count++;
                end
                if (out_word.found_within !== expected_word.found_within)
                begin
                    $error("found_within: expected %0d, actual %0d",
                           expected_word.found_within, out_word.found_within);
                    error_count++;
                end
            end
        end
    end

    // Query an empty store straight after reset
    task automatic test_empty_store();
        send_word(npms_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // Equal distances must keep the lowest slot; duplicates too
    task automatic test_ties_and_order();
        send_word(npms_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_LOAD, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_LOAD, 32'h0001_0000, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_LOAD, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_LOAD, 32'hFFFF_0000, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_QUERY, 32'h0000_8000, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_QUERY, 32'hFFFF_0000, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Widest distance and the strict compare at both ends of the limit
    task automatic test_limit_extremes();
        set_limit(LIMIT_MAX);
        send_word(npms_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(npms_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_limit(WORST_L1);
        send_word(npms_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_limit('0);
        send_word(npms_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_limit(34'd1);
        send_word(npms_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_limit(npms_pkg::LIMIT_RESET);
    endtask

    // Ignored command code, then a clear and an empty query
    task automatic test_unused_and_clear();
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_UNUSED, $urandom(), $urandom(), $urandom());
        send_word(npms_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(npms_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_word(npms_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    endtask

    // Fill every slot, target in the last one, then drop loads past capacity
    task automatic test_store_full();
        send_word(npms_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < npms_pkg::MAX_POINTS - 1; i++)
            send_word(npms_pkg::CMD_LOAD, jitter(32'h0, 32'h0080_0000),
                      jitter(32'h0, 32'h0080_0000), jitter(32'h0, 32'h0080_0000));
        send_word(npms_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (3)
            send_word(npms_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(npms_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(npms_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(npms_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0);
        send_word(npms_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
    endtask

    // Hold off the output for a long stretch while queries keep coming
    task automatic test_backpressure();
        send_word(npms_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        repeat (6) send_word(npms_pkg::CMD_LOAD, random_coord(32'h0), random_coord(32'h0),
                             random_coord(32'h0));
        hold_request = HOLD_CYCLES;
        no_idle      = 1'b1;
        repeat (8)
        begin
            send_word(npms_pkg::CMD_QUERY, random_coord(32'h0), random_coord(32'h0),
                      random_coord(32'h0));
            send_word(npms_pkg::CMD_LOAD, random_coord(32'h0), random_coord(32'h0),
                      random_coord(32'h0));
        end
        no_idle = 1'b0;
    endtask

    // Random sets: clear, load a cluster, query near stored points, with noise
    task automatic test_random_sets(logic [npms_pkg::DIST_W-1:0] limit_value, int target);
        int               counted;
        int               loads;
        logic [31:0]      centre;
        logic [31:0]      spread;
        npms_pkg::point_t pick;
        counted = 0;
        set_limit(limit_value);
        while (counted < target)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            centre  = $urandom();
            if ($urandom_range(0, 3) != 0)
            begin
                send_word(npms_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
                counted++;
            end
            loads = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(21, 100);
            repeat (loads)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_word(CMD_UNUSED, $urandom(), $urandom(), $urandom());
                send_word(npms_pkg::CMD_LOAD, random_coord(centre), random_coord(centre),
                          random_coord(centre));
                counted++;
            end
            repeat ($urandom_range(1, 4))
            begin
                if (stored_count != 0 && $urandom_range(0, 3) != 0)
                begin
                    pick = stored_points[$urandom_range(0, stored_count - 1)];
                    case ($urandom_range(0, 3))
                        0:       spread = 32'h0;
                        1:       spread = 32'h0000_0400;
                        2:       spread = 32'h0010_0000;
                        default: spread = 32'h0400_0000;
                    endcase
                    send_word(npms_pkg::CMD_QUERY, jitter(pick.x, spread),
                              jitter(pick.y, spread), jitter(pick.z, spread));
                end
                else
                    send_word(npms_pkg::CMD_QUERY, random_coord(centre), random_coord(centre),
                              random_coord(centre));
                counted++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        out_stall <= 1'b0;
        active_limit = npms_pkg::LIMIT_RESET;
        stored_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_ties_and_order();
        test_limit_extremes();
        test_unused_and_clear();
        test_store_full();
        test_backpressure();
        test_random_sets(npms_pkg::LIMIT_RESET, PHASE_WORDS);
        test_random_sets(LIMIT_MAX, PHASE_WORDS);
        test_random_sets('0, PHASE_WORDS);
        test_random_sets(LIMIT_FIFTY, PHASE_WORDS);
        test_random_sets({2'($urandom_range(0, 3)), $urandom()}, PHASE_WORDS);
        test_random_sets(npms_pkg::DIST_W'($urandom_range(0, 32'h0400_0000)), PHASE_WORDS);
        wait_idle();

        $display("Run covered %0d words, %0d query results (%0d within the limit)",
                 words_sent, queries_checked, matches_seen);
        $display("%0d loads dropped; limits from zero to the maximum, ties, a full store, %s",
                 dropped_loads, "a long output hold-off");
        if (error_count == 0)
            $display("** nearest_point_manhattan_search: PASSED **");
        else
            $display("** nearest_point_manhattan_search: FAILED **");
        $finish;
    end

endmodule

### nearest_point_manhattan_search.f
rtl/npms_pkg.sv
rtl/npms_dist_unit.sv
rtl/nearest_point_manhattan_search.sv
sim/tb_nearest_point_manhattan_search.sv
